[sv/nfa_pkg.sv]
`timescale 1ns / 1ps

package nfa_pkg;

   // fixed field widths
   localparam int OP_W       = 2;
   localparam int SYM_W      = 8;
   localparam int STATE_W    = 4;
   localparam int MASK_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // defaults for the top level parameters
   localparam int DEF_NUM_STATES    = 16;
   localparam int DEF_ALPHABET_SIZE = 256;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD_ARC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FEED     = 2'd1;
   localparam logic [OP_W-1:0] OP_END_WORD = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_MASK = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [SYM_W-1:0]   symbol;
      logic [STATE_W-1:0] from_state;
      logic [STATE_W-1:0] to_state;
      logic               sym_ok;
   } cmd_type;

   typedef struct packed {
      logic [STATE_W-1:0] start_state;
      logic [MASK_W-1:0]  accept_mask;
   } cfg_type;

endpackage

[sv/nfa_if.sv]
`timescale 1ns / 1ps

interface nfa_req_if;
   import nfa_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [SYM_W-1:0]   symbol;
   logic [STATE_W-1:0] from_state;
   logic [STATE_W-1:0] to_state;

   modport source (output valid, operation, symbol, from_state, to_state, input ready);
   modport sink   (input valid, operation, symbol, from_state, to_state, output ready);
endinterface

interface nfa_rsp_if;
   logic valid;
   logic ready;
   logic accepted;
   logic no_path;

   modport source (output valid, accepted, no_path, input ready);
   modport sink   (input valid, accepted, no_path, output ready);
endinterface

[sv/nfa_word_acceptance_unit.sv]
`timescale 1ns / 1ps
// NFA word acceptance unit: state-set simulation of a nondeterministic automaton.
// req_if carries one word per item: add arc (from, symbol, to), feed symbol, or
// end of word. rsp_if returns one word {accepted, no_path} per end of word only.
// csr_* writes start_state (index 0) and accept_mask (index 1); the user must
// write them only while idle, the block does not enforce it. A new start state
// is picked up at the next end of word. Throughput: one req word per cycle,
// sustained, for any mix of operations, while no sweep or rsp_if stall holds it.
// The set update is one banked read of the transition cells (a 1-bit RAM per
// source/destination pair, addressed by symbol) plus an OR across the rows. An
// end of word passes a queue slot, the read stage, then the rsp_if register.
// Reset: synchronous, active high. After reset the cell store is swept to zero,
// one symbol address per cycle over all ALPHABET_SIZE addresses (256 by default);
// req_if ready stays low during the sweep. The active set reloads with state 0.
// Stall: rsp_if has an output register; while it is held the back end keeps
// running feeds and arcs and stops only at the next end of word. The two-entry
// command queue then fills and req_if ready drops.
module nfa_word_acceptance_unit #(
   parameter int NUM_STATES    = nfa_pkg::DEF_NUM_STATES,
   parameter int ALPHABET_SIZE = nfa_pkg::DEF_ALPHABET_SIZE
) (
   input  logic                             clock,
   input  logic                             reset,
   nfa_req_if.sink                          req_if,
   nfa_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [nfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nfa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import nfa_pkg::*;

   cfg_type cfg_ff;

   logic    push;
   cmd_type push_cmd;
   logic    q_ready;
   logic    q_valid;
   cmd_type q_head;
   logic    q_pop;
   logic    clearing;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_STATE: cfg_ff.start_state <= csr_wdata[STATE_W-1:0];
            CSR_ACCEPT_MASK: cfg_ff.accept_mask <= csr_wdata[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: take words, drop the ones with no effect
   nfa_front #(
      .NUM_STATES    (NUM_STATES),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_front (
      .req_if   (req_if),
      .q_ready  (q_ready),
      .clearing (clearing),
      .push     (push),
      .push_cmd (push_cmd)
   );

   nfa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .ready    (q_ready),
      .valid    (q_valid),
      .head     (q_head),
      .pop      (q_pop)
   );

   // back: cell store, active set, response register
   nfa_back #(
      .NUM_STATES    (NUM_STATES),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (q_valid),
      .cmd       (q_head),
      .cmd_pop   (q_pop),
      .clearing  (clearing),
      .rsp_if    (rsp_if)
   );

endmodule

[sv/nfa_ram.sv]
`timescale 1ns / 1ps

module nfa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/nfa_front.sv]
`timescale 1ns / 1ps

module nfa_front #(
   parameter int NUM_STATES    = 16,
   parameter int ALPHABET_SIZE = 256
) (
   nfa_req_if.sink          req_if,
   input  logic             q_ready,
   input  logic             clearing,
   output logic             push,
   output nfa_pkg::cmd_type push_cmd
);
   import nfa_pkg::*;

   logic from_ok;
   logic to_ok;
   logic sym_ok;
   logic keep;

   assign from_ok = 32'(req_if.from_state) < NUM_STATES;
   assign to_ok   = 32'(req_if.to_state) < NUM_STATES;
   assign sym_ok  = 32'(req_if.symbol) < ALPHABET_SIZE;

   // drop unused codes and arcs that fall outside the automaton
   always_comb begin
      case (req_if.operation)
         OP_ADD_ARC:            keep = from_ok && to_ok && sym_ok;
         OP_FEED, OP_END_WORD:  keep = 1'b1;
         default:               keep = 1'b0;
      endcase
   end

   assign req_if.ready = q_ready && !clearing;
   assign push         = req_if.valid && req_if.ready && keep;

   assign push_cmd.op         = req_if.operation;
   assign push_cmd.symbol     = req_if.symbol;
   assign push_cmd.from_state = req_if.from_state;
   assign push_cmd.to_state   = req_if.to_state;
   assign push_cmd.sym_ok     = sym_ok;

endmodule

[sv/nfa_queue.sv]
`timescale 1ns / 1ps

module nfa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  nfa_pkg::cmd_type push_cmd,
   output logic             ready,
   output logic             valid,
   output nfa_pkg::cmd_type head,
   input  logic             pop
);
   import nfa_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign ready   = count_ff < (PTR_W+1)'(QUEUE_DEPTH);
   assign valid   = count_ff != '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && ready;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/nfa_back.sv]
`timescale 1ns / 1ps

module nfa_back #(
   parameter int NUM_STATES    = 16,
   parameter int ALPHABET_SIZE = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  nfa_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  nfa_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             clearing,
   nfa_rsp_if.source        rsp_if
);
   import nfa_pkg::*;

   localparam int SYM_AW = $clog2(ALPHABET_SIZE);

   // clearing sweep
   logic              clr_busy_ff, clr_busy_in;
   logic [SYM_AW-1:0] clr_addr_ff, clr_addr_in;

   // read stage
   logic              s2_valid_ff, s2_valid_in;
   logic [OP_W-1:0]   s2_op_ff;
   logic              s2_sym_ok_ff;
   logic              s2_fire;

   logic [NUM_STATES-1:0] active_ff, active_in;
   logic [NUM_STATES-1:0] next_set;
   logic [NUM_STATES-1:0] start_bits;
   logic [NUM_STATES-1:0] accept_bits;
   logic [NUM_STATES-1:0] row_q [NUM_STATES];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_accepted_ff;
   logic              rsp_no_path_ff;

   logic              rsp_free;
   logic              arc_wr;
   logic              feed_rd;
   logic [SYM_AW-1:0] ram_addr;

   assign clearing = clr_busy_ff;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign s2_fire  = s2_valid_ff && (s2_op_ff != OP_END_WORD || rsp_free);
   assign cmd_pop  = cmd_valid && !clr_busy_ff && (!s2_valid_ff || s2_fire);
   assign arc_wr   = cmd_pop && cmd.op == OP_ADD_ARC;
   assign feed_rd  = cmd_pop && cmd.op == OP_FEED;
   assign ram_addr = clr_busy_ff ? clr_addr_ff : cmd.symbol[SYM_AW-1:0];

   // one bit cell per (source, destination), addressed by symbol
   for (genvar i = 0; i < NUM_STATES; i++) begin : g_src
      logic from_hit;
      assign from_hit = 32'(cmd.from_state) == i;
      assign start_bits[i] = 32'(cfg.start_state) == i;
      if (i < MASK_W) begin : g_acc
         assign accept_bits[i] = cfg.accept_mask[i];
      end else begin : g_noacc
         assign accept_bits[i] = 1'b0;
      end
      for (genvar j = 0; j < NUM_STATES; j++) begin : g_dst
         logic to_hit;
         assign to_hit = 32'(cmd.to_state) == j;
         nfa_ram #(
            .WIDTH (1),
            .DEPTH (ALPHABET_SIZE)
         ) u_cell (
            .clock   (clock),
            .wr_en   (clr_busy_ff || (arc_wr && from_hit && to_hit)),
            .wr_addr (ram_addr),
            .wr_data (!clr_busy_ff),
            .rd_en   (feed_rd),
            .rd_addr (ram_addr),
            .rd_data (row_q[i][j])
         );
      end
   end

   // union of successor rows of the active states; empty for a symbol outside the alphabet
   always_comb begin
      next_set = '0;
      for (int i = 0; i < NUM_STATES; i++) begin
         if (active_ff[i]) begin
            next_set = next_set | row_q[i];
         end
      end
      if (!s2_sym_ok_ff) begin
         next_set = '0;
      end
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == SYM_AW'(ALPHABET_SIZE - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      s2_valid_in = s2_valid_ff;
      if (cmd_pop) begin
         s2_valid_in = 1'b1;
      end else if (s2_fire) begin
         s2_valid_in = 1'b0;
      end

      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s2_fire) begin
         case (s2_op_ff)
            OP_FEED: begin
               active_in = next_set;
            end
            OP_END_WORD: begin
               active_in    = start_bits;
               rsp_valid_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s2_valid_ff  <= 1'b0;
         active_ff    <= {{(NUM_STATES-1){1'b0}}, 1'b1};
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s2_valid_ff  <= s2_valid_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd_pop) begin
         s2_op_ff     <= cmd.op;
         s2_sym_ok_ff <= cmd.sym_ok;
      end
      if (s2_fire && s2_op_ff == OP_END_WORD) begin
         rsp_accepted_ff <= (active_ff & accept_bits) != '0;
         rsp_no_path_ff  <= active_ff == '0;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.accepted = rsp_accepted_ff;
   assign rsp_if.no_path  = rsp_no_path_ff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import nfa_pkg::*;

   // op code 3 has no meaning; the block must swallow it without a result
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int N_STATES     = DEF_NUM_STATES;
   localparam int N_SYMBOLS    = DEF_ALPHABET_SIZE;
   localparam int DRAIN_CYCLES = 8;   // covers queue + cell read + rsp register
   localparam int JUNK_W       = CSR_DATA_W - STATE_W;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [SYM_W-1:0]   symbol;
      logic [STATE_W-1:0] from_state;
      logic [STATE_W-1:0] to_state;
   } word_type;

   typedef struct packed {
      logic accepted;
      logic no_path;
   } verdict_type;

   typedef enum {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      word_type               w;
      bit                     typed;   // verdict below is taken as is
      verdict_type            v;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  val;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   nfa_req_if req_bus ();
   nfa_rsp_if rsp_bus ();

   nfa_word_acceptance_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------
   // Shadow automaton: successor cells, live set, register copies
   // ---------------------------------------------------------------
   logic [N_STATES-1:0] succ_cells [0:N_STATES*N_SYMBOLS-1];
   logic [N_STATES-1:0] live_set;
   logic [STATE_W-1:0]  cfg_start;
   logic [MASK_W-1:0]   cfg_mask;

   verdict_type         verdict_q [$];   // verdicts owed by the block, oldest first
   plan_row_type        directed_plan [$];
   logic [SYM_W-1:0]    phase_alpha [3]; // small alphabet so words go somewhere
   int                  reach_pool [$];  // states likely live in this phase
   int                  word_count;
   int                  fail_count;
   int                  rx_hold;
   bit                  tx_idle_on;
   bit                  rx_stall_on;

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic logic [N_STATES-1:0] start_bits(input logic [STATE_W-1:0] st);
      return {{(N_STATES-1){1'b0}}, 1'b1} << st;
   endfunction

   // Apply one accepted word to the shadow; returns the verdict if it owes one.
   task automatic predict_word(input word_type w, output bit has_v,
                               output verdict_type v);
      logic [N_STATES-1:0] next_set;
      has_v = 1'b0;
      v     = '0;
      case (w.op)
         OP_ADD_ARC: begin
            succ_cells[{w.from_state, w.symbol}][w.to_state] = 1'b1;
         end
         OP_FEED: begin
            next_set = '0;
            for (int s = 0; s < N_STATES; s++)
               if (live_set[s])
                  next_set |= succ_cells[{STATE_W'(s), w.symbol}];
            live_set = next_set;
         end
         OP_END_WORD: begin
            v.accepted = |(live_set & cfg_mask);
            v.no_path  = (live_set == '0);
            live_set   = start_bits(cfg_start);
            has_v      = 1'b1;
         end
         default: ;
      endcase
   endtask

   function automatic word_type mk_word(input logic [OP_W-1:0] op,
                                        input logic [SYM_W-1:0] sym,
                                        input logic [STATE_W-1:0] from_s,
                                        input logic [STATE_W-1:0] to_s);
      word_type w;
      w.op         = op;
      w.symbol     = sym;
      w.from_state = from_s;
      w.to_state   = to_s;
      return w;
   endfunction

   function automatic plan_row_type row_word(input logic [OP_W-1:0] op,
                                             input logic [SYM_W-1:0] sym,
                                             input logic [STATE_W-1:0] from_s,
                                             input logic [STATE_W-1:0] to_s);
      plan_row_type r;
      r.kind  = ROW_WORD;
      r.w     = mk_word(op, sym, from_s, to_s);
      r.typed = 1'b0;
      r.v     = '0;
      r.idx   = '0;
      r.val   = '0;
      return r;
   endfunction

   function automatic plan_row_type row_end(input bit typed, input logic acc,
                                            input logic nop);
      plan_row_type r;
      r            = row_word(OP_END_WORD, '0, '0, '0);
      r.typed      = typed;
      r.v.accepted = acc;
      r.v.no_path  = nop;
      return r;
   endfunction

   function automatic plan_row_type row_csr(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      plan_row_type r;
      r      = row_word(OP_UNUSED, '0, '0, '0);
      r.kind = ROW_CSR;
      r.idx  = idx;
      r.val  = val;
      return r;
   endfunction

   // append one row at the end of the directed table
   function automatic void add_row(input plan_row_type r);
      directed_plan.insert(directed_plan.size(), r);
   endfunction

   // Present one word and hold it until taken. valid is left high so a
   // following word can go out back to back.
   task automatic send_word(input word_type w, input bit typed = 1'b0,
                            input verdict_type fixed = '0);
      bit          has_v;
      verdict_type v;
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= w.op;
      req_bus.symbol     <= w.symbol;
      req_bus.from_state <= w.from_state;
      req_bus.to_state   <= w.to_state;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      predict_word(w, has_v, v);
      if (has_v)
         verdict_q.insert(verdict_q.size(), typed ? fixed : v);
      if (w.op != OP_UNUSED)
         word_count++;
   endtask

   // Stop sending, let all owed verdicts arrive, then let feeds/arcs still
   // in the pipe settle before anything touches the registers.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // csr_we is left high; the caller drops it after the last write of a batch
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_START_STATE)
         cfg_start = val[STATE_W-1:0];
      else
         cfg_mask = val;
   endtask

   function automatic logic [SYM_W-1:0] pick_symbol();
      if ($urandom_range(0, 9) != 0)
         return phase_alpha[$urandom_range(0, 2)];
      return SYM_W'($urandom_range(0, N_SYMBOLS - 1));
   endfunction

   // Arcs mostly leave states that are likely live, so words reach deep.
   task automatic random_arc();
      logic [STATE_W-1:0] from_s;
      logic [STATE_W-1:0] to_s;
      if ($urandom_range(0, 9) < 6)
         from_s = STATE_W'(reach_pool[$urandom_range(0, reach_pool.size() - 1)]);
      else
         from_s = STATE_W'($urandom_range(0, N_STATES - 1));
      to_s = STATE_W'($urandom_range(0, N_STATES - 1));
      send_word(mk_word(OP_ADD_ARC, pick_symbol(), from_s, to_s));
      if (reach_pool.size() < N_STATES)
         reach_pool.insert(reach_pool.size(), to_s);
   endtask

   // One random phase: new register settings, a seed automaton, then mostly
   // well-formed words with arcs mixed in, plus ignored codes and stray symbols.
   task automatic run_phase(input int n_words, input logic [STATE_W-1:0] st,
                            input logic [MASK_W-1:0] mk, input bit calm);
      int goal;
      int len;
      int pick;
      wait_idle();
      // junk in the upper data bits must not leak into start_state
      csr_write(CSR_START_STATE, {JUNK_W'($urandom), st});
      csr_write(CSR_ACCEPT_MASK, mk);
      csr_we      <= 1'b0;
      tx_idle_on  = !calm;
      rx_stall_on = !calm;
      foreach (phase_alpha[k])
         phase_alpha[k] = SYM_W'($urandom_range(0, N_SYMBOLS - 1));
      reach_pool.delete();
      reach_pool.insert(0, st);
      goal = word_count + n_words;
      repeat (10) random_arc();
      while (word_count < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            random_arc();
         end else if (pick < 85) begin
            len = $urandom_range(0, 6);
            repeat (len) begin
               if ($urandom_range(0, 9) == 0)
                  random_arc();
               else
                  send_word(mk_word(OP_FEED, pick_symbol(),
                                    STATE_W'($urandom_range(0, N_STATES - 1)),
                                    STATE_W'($urandom_range(0, N_STATES - 1))));
            end
            send_word(mk_word(OP_END_WORD, SYM_W'($urandom_range(0, N_SYMBOLS - 1)),
                              STATE_W'($urandom_range(0, N_STATES - 1)),
                              STATE_W'($urandom_range(0, N_STATES - 1))));
         end else if (pick < 93) begin
            send_word(mk_word(OP_UNUSED, SYM_W'($urandom_range(0, N_SYMBOLS - 1)),
                              STATE_W'($urandom_range(0, N_STATES - 1)),
                              STATE_W'($urandom_range(0, N_STATES - 1))));
         end else begin
            // stray symbol from the full alphabet, often kills the set
            send_word(mk_word(OP_FEED, SYM_W'($urandom_range(0, N_SYMBOLS - 1)),
                              STATE_W'($urandom_range(0, N_STATES - 1)),
                              STATE_W'($urandom_range(0, N_STATES - 1))));
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Result side: random back-pressure bursts on rsp_bus.ready
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         rx_hold       <= rx_hold - 1;
      end else if (rx_stall_on && $urandom_range(0, 4) == 0) begin
         rsp_bus.ready <= 1'b0;
         rx_hold       <= $urandom_range(0, 3);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Every taken result is checked against the oldest owed verdict.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (verdict_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: accepted=%0b no_path=%0b",
                        rsp_bus.accepted, rsp_bus.no_path);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_bus.accepted !== want.accepted || rsp_bus.no_path !== want.no_path) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"mismatch: expected accepted=%0b no_path=%0b, ",
                            "got accepted=%0b no_path=%0b"},
                           want.accepted, want.no_path, rsp_bus.accepted, rsp_bus.no_path);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.operation  = '0;
      req_bus.symbol     = '0;
      req_bus.from_state = '0;
      req_bus.to_state   = '0;
      rsp_bus.ready      = 1'b0;
      rx_hold            = 0;
      tx_idle_on         = 1'b1;
      rx_stall_on        = 1'b1;
      word_count         = 0;
      fail_count         = 0;

      // shadow comes up as the block does after reset and sweep
      foreach (succ_cells[a])
         succ_cells[a] = '0;
      cfg_start = '0;
      cfg_mask  = '0;
      live_set  = start_bits('0);

      // empty word right after reset, mask all clear
      add_row(row_end(1'b1, 1'b0, 1'b0));
      // symbol with no arcs anywhere empties the set
      add_row(row_word(OP_FEED, 8'hFF, 4'h0, 4'h0));
      add_row(row_end(1'b1, 1'b0, 1'b1));
      // set was reloaded: empty word tests start state alone
      add_row(row_end(1'b1, 1'b0, 1'b0));
      // unused op with every field bit high is dropped
      add_row(row_word(OP_UNUSED, 8'hFF, 4'hF, 4'hF));
      // corner arcs plus a nondeterministic fork on symbol 0x00
      add_row(row_word(OP_ADD_ARC, 8'h00, 4'h0, 4'hF));
      add_row(row_word(OP_ADD_ARC, 8'hFF, 4'hF, 4'h0));
      add_row(row_word(OP_ADD_ARC, 8'h00, 4'h0, 4'h1));
      add_row(row_word(OP_FEED, 8'h00, 4'h0, 4'h0));
      add_row(row_word(OP_FEED, 8'hFF, 4'h0, 4'h0));
      add_row(row_end(1'b0, 1'b0, 1'b0));
      add_row(row_csr(CSR_ACCEPT_MASK, 16'hFFFF));
      add_row(row_csr(CSR_START_STATE, 16'h000F));
      // new start state waits for the next reload: this word still runs from 0
      add_row(row_end(1'b1, 1'b1, 1'b0));
      add_row(row_end(1'b1, 1'b1, 1'b0));
      add_row(row_word(OP_FEED, 8'h00, 4'h0, 4'h0));
      add_row(row_end(1'b1, 1'b0, 1'b1));
      add_row(row_csr(CSR_ACCEPT_MASK, 16'h8000));
      add_row(row_word(OP_FEED, 8'hFF, 4'h0, 4'h0));
      add_row(row_word(OP_FEED, 8'h00, 4'h0, 4'h0));
      add_row(row_end(1'b0, 1'b0, 1'b0));
      add_row(row_csr(CSR_START_STATE, 16'h0000));
      add_row(row_csr(CSR_ACCEPT_MASK, 16'h0001));
      add_row(row_end(1'b0, 1'b0, 1'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < directed_plan.size(); i++) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            if (i == 0 || directed_plan[i-1].kind != ROW_CSR)
               wait_idle();
            csr_write(directed_plan[i].idx, directed_plan[i].val);
            if (i + 1 == directed_plan.size() || directed_plan[i+1].kind != ROW_CSR)
               csr_we <= 1'b0;
         end else begin
            send_word(directed_plan[i].w, directed_plan[i].typed, directed_plan[i].v);
         end
      end

      run_phase(130, 4'hF, 16'hFFFF, 1'b0);
      run_phase(130, 4'h0, 16'h0001, 1'b0);
      run_phase(130, STATE_W'($urandom_range(0, N_STATES - 1)), MASK_W'($urandom), 1'b0);
      run_phase(130, STATE_W'($urandom_range(0, N_STATES - 1)), 16'h8000, 1'b0);
      run_phase(130, STATE_W'($urandom_range(0, N_STATES - 1)), MASK_W'($urandom), 1'b0);
      // closing stretch at full rate, no idling on either side
      run_phase(100, STATE_W'($urandom_range(0, N_STATES - 1)), MASK_W'($urandom), 1'b1);

      wait_idle();
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog: far beyond the slowest legal run (sweep, stalls, gaps)
   initial begin
      #200000;
      $display("FAILURE");
      $finish;
   end

endmodule
